### src/lco_pkg.sv
// ----------------------------------------------------------------------------
// Line clip outcode package
// Shared constants, region code bits, register indexes and sequencer states
// for the outcode line clipper.
// ----------------------------------------------------------------------------
package lco_pkg;

  // Default geometry: integer pixel bits and fraction bits of the results
  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 4;

  // Window reset values, integer pixels
  localparam int WIN_LEFT_RST   = 50;
  localparam int WIN_BOTTOM_RST = 50;
  localparam int WIN_RIGHT_RST  = 400;
  localparam int WIN_TOP_RST    = 400;

  // Region code bit positions
  localparam int CODE_LEFT   = 0;
  localparam int CODE_RIGHT  = 1;
  localparam int CODE_BOTTOM = 2;
  localparam int CODE_TOP    = 3;
  localparam int CODE_W      = 4;

  // Clip step limit and the counter that holds it
  localparam int MAX_STEPS = 8;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_WIN_LEFT   = 2'd0,
    REG_WIN_BOTTOM = 2'd1,
    REG_WIN_RIGHT  = 2'd2,
    REG_WIN_TOP    = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_PREP,
    S_DIV,
    S_APPLY,
    S_DONE
  } state_t;

endpackage

### src/line_clip_outcode.sv
// ----------------------------------------------------------------------------
// Line clip outcode
// Clips one segment against the configured window with four-bit region
// codes; each clip step finds the edge crossing with one multiply and a
// serial restoring divide, then moves the outside endpoint onto the edge.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake          | Payload (lowest bits first)
// s_*      | in  | s_tvalid/s_tready  | start_x, start_y, end_x, end_y
// m_*      | out | m_tvalid/m_tready  | visible, clip_start_x, clip_start_y,
//          |     |                    | clip_end_x, clip_end_y
// cfg_*    | in  | cfg_wr             | cfg_index selects register, cfg_data
//
// One item takes k clip steps, k at most 4 on a proper window and 8 at most.
// Each step runs the shared divider, one quotient bit per cycle, which sets
// the rate.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register, and the next item may be taken meanwhile.
// Reset (rst, synchronous) returns the window to its defaults and drops any
// item in flight.
// ----------------------------------------------------------------------------
module line_clip_outcode #(
  parameter int COORD_BITS = lco_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lco_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // start_x, start_y, end_x, end_y (COORD_BITS each), zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y
  // (COORD_BITS+FRAC_BITS each), zero padded
  output logic [((1+4*(COORD_BITS+FRAC_BITS)+7)/8)*8-1:0] m_tdata,
  output logic                                            m_tvalid,
  input  logic                                            m_tready,
  // configuration write port
  input  logic                              cfg_wr,
  input  logic [lco_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]             cfg_data
);
  import lco_pkg::*;

  localparam int CW     = COORD_BITS + FRAC_BITS;
  localparam int OUT_W  = ((1 + 4*CW + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - 1 - 4*CW;
  localparam int CNT_W  = $clog2(CW);

  // Window registers
  logic [COORD_BITS-1:0] win_left, win_bottom, win_right, win_top;
  logic [CW-1:0]         xl, xr, yb, yt;

  // Sequencer
  state_t state, state_next;

  // Endpoints and step count
  logic [CW-1:0]     x1, y1, x2, y2;
  logic [STEP_W-1:0] step;
  logic              ok;

  // Crossing operands
  logic                 move1;
  logic                 edge_is_y;
  logic [CW-1:0]        edge_val;
  logic [CW-1:0]        base;
  logic signed [CW:0]   op_a, op_b, dq;
  logic signed [2*CW+1:0] prod;
  logic                 neg;

  // Divider
  logic [CW-1:0]    rem, quo, ad;
  logic [CNT_W-1:0] div_cnt;

  // Combinational helpers
  logic [CODE_W-1:0] c1, c2, co;
  logic [CW-1:0]     p1_sel, q1_sel, p2_sel, q2_sel, edge_sel;
  logic              out_free;
  logic              prod_neg, dq_neg;
  logic signed [2*CW+1:0] prod_mag;
  logic signed [CW:0]     dq_mag;
  logic [2*CW-1:0]   num;
  logic [CW:0]       div_try;
  logic              div_ge;
  logic [CW-1:0]     cross_pt;

  function automatic logic [CODE_W-1:0] region(
    input logic [CW-1:0] x, input logic [CW-1:0] y,
    input logic [CW-1:0] l, input logic [CW-1:0] r,
    input logic [CW-1:0] b, input logic [CW-1:0] t
  );
    logic [CODE_W-1:0] c;
    c = '0;
    c[CODE_LEFT]   = x < l;
    c[CODE_RIGHT]  = x > r;
    c[CODE_BOTTOM] = y < b;
    c[CODE_TOP]    = y > t;
    return c;
  endfunction

  // Window edges in fixed point
  assign xl = CW'(win_left)   << FRAC_BITS;
  assign xr = CW'(win_right)  << FRAC_BITS;
  assign yb = CW'(win_bottom) << FRAC_BITS;
  assign yt = CW'(win_top)    << FRAC_BITS;

  // Region codes and edge choice of the current step
  always_comb begin
    c1 = region(x1, y1, xl, xr, yb, yt);
    c2 = region(x2, y2, xl, xr, yb, yt);
    co = (c1 != '0) ? c1 : c2;
    if (co[CODE_TOP] || co[CODE_BOTTOM]) begin
      edge_sel = co[CODE_TOP] ? yt : yb;
      p1_sel = x1;
      q1_sel = y1;
      p2_sel = x2;
      q2_sel = y2;
    end else begin
      edge_sel = co[CODE_LEFT] ? xl : xr;
      p1_sel = y1;
      q1_sel = x1;
      p2_sel = y2;
      q2_sel = x2;
    end
  end

  // Magnitudes and rounded dividend
  always_comb begin
    prod_neg = prod[2*CW+1];
    prod_mag = prod_neg ? -prod : prod;
    dq_neg   = dq[CW];
    dq_mag   = dq_neg ? -dq : dq;
    num      = prod_mag[2*CW-1:0] + (2*CW)'(dq_mag[CW-1:0] >> 1);
  end

  // Restoring divide step and crossing result
  assign div_try  = {rem, quo[CW-1]};
  assign div_ge   = div_try >= {1'b0, ad};
  assign cross_pt = neg ? (base - quo) : (base + quo);

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_EVAL;
      S_EVAL: begin
        if ((c1 | c2) == '0 || (c1 & c2) != '0 || step >= STEP_W'(MAX_STEPS)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL:   state_next = S_PREP;
      S_PREP:  state_next = (dq == '0) ? S_APPLY : S_DIV;
      S_DIV:   if (div_cnt == '0) state_next = S_APPLY;
      S_APPLY: state_next = S_EVAL;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= COORD_BITS'(WIN_LEFT_RST);
      win_bottom <= COORD_BITS'(WIN_BOTTOM_RST);
      win_right  <= COORD_BITS'(WIN_RIGHT_RST);
      win_top    <= COORD_BITS'(WIN_TOP_RST);
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIN_LEFT:   win_left   <= cfg_data;
        REG_WIN_BOTTOM: win_bottom <= cfg_data;
        REG_WIN_RIGHT:  win_right  <= cfg_data;
        REG_WIN_TOP:    win_top    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      // load endpoints on the accepted transaction
      S_IDLE: begin
        if (s_tvalid) begin
          x1   <= CW'(s_tdata[0*COORD_BITS +: COORD_BITS]) << FRAC_BITS;
          y1   <= CW'(s_tdata[1*COORD_BITS +: COORD_BITS]) << FRAC_BITS;
          x2   <= CW'(s_tdata[2*COORD_BITS +: COORD_BITS]) << FRAC_BITS;
          y2   <= CW'(s_tdata[3*COORD_BITS +: COORD_BITS]) << FRAC_BITS;
          step <= '0;
        end
      end
      // decide accept, reject or another clip step
      S_EVAL: begin
        ok        <= (c1 | c2) == '0;
        move1     <= c1 != '0;
        edge_is_y <= co[CODE_TOP] || co[CODE_BOTTOM];
        edge_val  <= edge_sel;
        base      <= p1_sel;
        op_a      <= $signed({1'b0, edge_sel}) - $signed({1'b0, q1_sel});
        op_b      <= $signed({1'b0, p2_sel}) - $signed({1'b0, p1_sel});
        dq        <= $signed({1'b0, q2_sel}) - $signed({1'b0, q1_sel});
      end
      S_MUL: begin
        prod <= op_a * op_b;
      end
      // load the divider with the rounded magnitude
      S_PREP: begin
        neg     <= prod_neg ^ dq_neg;
        ad      <= dq_mag[CW-1:0];
        rem     <= num[2*CW-1:CW];
        quo     <= (dq == '0) ? '0 : num[CW-1:0];
        div_cnt <= CNT_W'(CW - 1);
      end
      // one quotient bit per cycle
      S_DIV: begin
        rem     <= div_ge ? CW'(div_try - {1'b0, ad}) : div_try[CW-1:0];
        quo     <= {quo[CW-2:0], div_ge};
        div_cnt <= div_cnt - 1'b1;
      end
      // move the outside endpoint onto the edge
      S_APPLY: begin
        if (move1) begin
          x1 <= edge_is_y ? cross_pt : edge_val;
          y1 <= edge_is_y ? edge_val : cross_pt;
        end else begin
          x2 <= edge_is_y ? cross_pt : edge_val;
          y2 <= edge_is_y ? edge_val : cross_pt;
        end
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      if (ok) begin
        m_tdata <= {{OUT_PAD{1'b0}}, y2, x2, y1, x1, 1'b1};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

### tb/sv/line_clip_outcode_test.sv
// ----------------------------------------------------------------------------
// Line clip outcode testbench
// Streams line segments through the outcode clipper under several windows
// (reset default, full screen, random, inverted, zero-width, single-pixel)
// and compares every clipped result with an in-bench Cohen-Sutherland
// predictor. Valid and ready are throttled at random in the first four batches.
// ----------------------------------------------------------------------------
module line_clip_outcode_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lco_pkg::*;

  localparam int CW   = COORD_BITS_DEF;
  localparam int FW   = FRAC_BITS_DEF;
  localparam int OW   = CW + FW;
  localparam int SW   = ((4 * CW + 7) / 8) * 8;
  localparam int MW   = ((1 + 4 * OW + 7) / 8) * 8;
  localparam int CMAX = 2 ** CW - 1;
  localparam int TAIL_CYCLES = 160;

  // One segment, laid out as on s_tdata (start_x lowest)
  typedef struct packed {
    logic [CW-1:0] ey;
    logic [CW-1:0] ex;
    logic [CW-1:0] sy;
    logic [CW-1:0] sx;
  } segment_t;

  // One clipped result, laid out as the low bits of m_tdata (visible lowest)
  typedef struct packed {
    logic [OW-1:0] ey;
    logic [OW-1:0] ex;
    logic [OW-1:0] sy;
    logic [OW-1:0] sx;
    logic          visible;
  } clip_t;

  // Predicts clipped segments and checks them in order of arrival
  class clip_tracker;
    longint xl, xr, yb, yt;
    clip_t  expected_clips[$];
    int     errors;

    function new();
      xl = longint'(WIN_LEFT_RST) << FW;
      yb = longint'(WIN_BOTTOM_RST) << FW;
      xr = longint'(WIN_RIGHT_RST) << FW;
      yt = longint'(WIN_TOP_RST) << FW;
      errors = 0;
    endfunction

    function void set_window(reg_idx_t idx, logic [CW-1:0] value);
      longint scaled;
      scaled = longint'(value) << FW;
      case (idx)
        REG_WIN_LEFT:   xl = scaled;
        REG_WIN_BOTTOM: yb = scaled;
        REG_WIN_RIGHT:  xr = scaled;
        REG_WIN_TOP:    yt = scaled;
        default: ;
      endcase
    endfunction

    function logic [CODE_W-1:0] region(longint x, longint y);
      logic [CODE_W-1:0] c;
      c = '0;
      c[CODE_LEFT]   = (x < xl);
      c[CODE_RIGHT]  = (x > xr);
      c[CODE_BOTTOM] = (y < yb);
      c[CODE_TOP]    = (y > yt);
      return c;
    endfunction

    // Quotient rounded to nearest, ties away from zero
    function longint round_div(longint num, longint den);
      bit     neg;
      longint an, ad, q;
      neg = (num < 0) != (den < 0);
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q = (an + ad / 2) / ad;
      return neg ? -q : q;
    endfunction

    // Coordinate p where the segment meets q == bound; flat runs keep p1
    function longint edge_cross(longint p1, longint q1, longint p2, longint q2,
                                longint bound);
      longint dq;
      dq = q2 - q1;
      if (dq == 0) return p1;
      return p1 + round_div((bound - q1) * (p2 - p1), dq);
    endfunction

    function clip_t clip_segment(segment_t seg);
      longint            x1, y1, x2, y2, nx, ny;
      logic [CODE_W-1:0] c1, c2, co;
      int                steps;
      bit                ok;
      clip_t             r;
      x1 = longint'(seg.sx) << FW;
      y1 = longint'(seg.sy) << FW;
      x2 = longint'(seg.ex) << FW;
      y2 = longint'(seg.ey) << FW;
      c1 = region(x1, y1);
      c2 = region(x2, y2);
      ok = 1'b1;
      steps = 0;
      // Move the outside endpoint onto an edge until both codes clear
      while ((c1 | c2) != '0) begin
        if ((c1 & c2) != '0 || steps >= MAX_STEPS) begin
          ok = 1'b0;
          break;
        end
        steps++;
        co = (c1 != '0) ? c1 : c2;
        if (co[CODE_TOP]) begin
          ny = yt;
          nx = edge_cross(x1, y1, x2, y2, yt);
        end else if (co[CODE_BOTTOM]) begin
          ny = yb;
          nx = edge_cross(x1, y1, x2, y2, yb);
        end else if (co[CODE_LEFT]) begin
          nx = xl;
          ny = edge_cross(y1, x1, y2, x2, xl);
        end else begin
          nx = xr;
          ny = edge_cross(y1, x1, y2, x2, xr);
        end
        if (c1 != '0) begin
          x1 = nx;
          y1 = ny;
          c1 = region(x1, y1);
        end else begin
          x2 = nx;
          y2 = ny;
          c2 = region(x2, y2);
        end
      end
      r = '0;
      if (ok) begin
        r.visible = 1'b1;
        r.sx = x1[OW-1:0];
        r.sy = y1[OW-1:0];
        r.ex = x2[OW-1:0];
        r.ey = y2[OW-1:0];
      end
      return r;
    endfunction

    function void note_segment(segment_t seg);
      expected_clips.push_back(clip_segment(seg));
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_clip(logic [MW-1:0] data);
      clip_t got, want;
      got = data[4*OW:0];
      if (expected_clips.size() == 0) begin
        errors++;
        $display("%0t clip result with none expected: expected none actual %h",
                 $time, data);
        return;
      end
      want = expected_clips.pop_front();
      compare("visible", want.visible, got.visible);
      compare("clip_start_x", want.sx, got.sx);
      compare("clip_start_y", want.sy, got.sy);
      compare("clip_end_x", want.ex, got.ex);
      compare("clip_end_y", want.ey, got.ey);
      compare("tdata padding", 0, data[MW-1:4*OW+1]);
    endfunction

    function int pending();
      return expected_clips.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic [SW-1:0]        s_tdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [MW-1:0]        m_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic                 cfg_wr = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_WIN_LEFT;
  logic [CW-1:0]        cfg_data = '0;

  int send_idle = 0;
  int recv_idle = 0;
  int win_l = WIN_LEFT_RST;
  int win_b = WIN_BOTTOM_RST;
  int win_r = WIN_RIGHT_RST;
  int win_t = WIN_TOP_RST;

  clip_tracker tracker = new();

  line_clip_outcode DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic segment_t seg(int sx, int sy, int ex, int ey);
    segment_t s;
    s.sx = CW'(sx);
    s.sy = CW'(sy);
    s.ex = CW'(ex);
    s.ey = CW'(ey);
    return s;
  endfunction

  // Coordinate within a margin around the span between two window edges
  function automatic int near_span(int a, int b);
    int lo, hi;
    lo = ((a < b) ? a : b) - 40;
    hi = ((a < b) ? b : a) + 40;
    if (lo < 0) lo = 0;
    if (hi > CMAX) hi = CMAX;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int inside_span(int a, int b);
    return (a < b) ? $urandom_range(b, a) : $urandom_range(a, b);
  endfunction

  // Screen limits, window edges and their immediate neighbors
  function automatic int edge_pick(int a, int b);
    case ($urandom_range(5))
      0: return 0;
      1: return CMAX;
      2: return a;
      3: return b;
      4: return (a > 0) ? a - 1 : 0;
      default: return (b < CMAX) ? b + 1 : CMAX;
    endcase
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    s = seg($urandom_range(CMAX), $urandom_range(CMAX),
            $urandom_range(CMAX), $urandom_range(CMAX));
    case ($urandom_range(9))
      3, 4: s = seg(near_span(win_l, win_r), near_span(win_b, win_t),
                    near_span(win_l, win_r), near_span(win_b, win_t));
      5: s.ex = s.sx;
      6: s.ey = s.sy;
      7: begin
        if ($urandom_range(1)) begin
          s.sx = CW'(inside_span(win_l, win_r));
          s.sy = CW'(inside_span(win_b, win_t));
        end else begin
          s.ex = CW'(inside_span(win_l, win_r));
          s.ey = CW'(inside_span(win_b, win_t));
        end
      end
      8: s = seg(inside_span(win_l, win_r), inside_span(win_b, win_t),
                 inside_span(win_l, win_r), inside_span(win_b, win_t));
      9: s = seg(edge_pick(win_l, win_r), edge_pick(win_b, win_t),
                 edge_pick(win_l, win_r), edge_pick(win_b, win_t));
      default: ;
    endcase
    return s;
  endfunction

  task automatic write_window_reg(reg_idx_t idx, int value);
    @(negedge clk);
    cfg_wr    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CW'(value);
    tracker.set_window(idx, CW'(value));
  endtask

  task automatic set_window(int l, int b, int r, int t);
    write_window_reg(REG_WIN_LEFT, l);
    write_window_reg(REG_WIN_BOTTOM, b);
    write_window_reg(REG_WIN_RIGHT, r);
    write_window_reg(REG_WIN_TOP, t);
    @(negedge clk);
    cfg_wr <= 1'b0;
    win_l = l;
    win_b = b;
    win_r = r;
    win_t = t;
  endtask

  // Offer one segment, idling first at random, and hold it until taken
  task automatic send_segment(segment_t s);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= SW'({$urandom(), $urandom()});
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= s;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_segment(s);
  endtask

  // Drop valid and wait until every clipped result is back
  task automatic drain_clips();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Result side: sample at the rising edge, throttle ready at the falling edge
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.check_clip(m_tdata);
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    int l, b, r, t;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed segments against the reset window
    send_segment(seg(0, 0, 0, 0));
    send_segment(seg(1023, 1023, 1023, 1023));
    send_segment(seg(100, 100, 300, 300));
    send_segment(seg(50, 50, 400, 400));
    send_segment(seg(0, 0, 1023, 1023));
    send_segment(seg(1023, 1023, 0, 0));
    send_segment(seg(200, 0, 200, 1023));
    send_segment(seg(0, 200, 1023, 200));
    send_segment(seg(10, 10, 30, 700));
    send_segment(seg(0, 300, 300, 1023));
    send_segment(seg(0, 1023, 1023, 0));
    send_segment(seg(225, 225, 1023, 300));
    send_segment(seg(1023, 0, 225, 225));
    send_segment(seg(49, 225, 401, 226));
    send_segment(seg(225, 401, 226, 49));
    send_segment(seg(0, 51, 1023, 52));
    send_segment(seg(682, 1023, 341, 0));
    send_segment(seg(341, 682, 682, 341));
    send_segment(seg(300, 0, 301, 1023));

    // Inverted window: codes never clear, so every segment is rejected
    drain_clips();
    set_window(1023, 1023, 0, 0);
    send_segment(seg(0, 1023, 1023, 0));
    send_segment(seg(0, 0, 1023, 1023));
    send_segment(seg(512, 512, 512, 512));
    send_segment(seg(0, 512, 1023, 512));

    // Random segments, one window per batch
    for (int p = 0; p < 6; p++) begin
      drain_clips();
      case (p)
        0: set_window(0, 0, 1023, 1023);
        2: set_window(600, 600, 300, 300);
        3: set_window(512, 512, 512, 512);
        4: set_window(1023, 0, 1023, 1023);
        default: begin
          l = $urandom_range(600);
          b = $urandom_range(600);
          r = $urandom_range(1023, l);
          t = $urandom_range(1023, b);
          set_window(l, b, r, t);
        end
      endcase
      case (p / 2)
        0: begin
          send_idle = 28;
          recv_idle = 71;
        end
        1: begin
          send_idle = 71;
          recv_idle = 28;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      repeat (67) send_segment(random_segment());
    end

    drain_clips();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[line_clip_outcode] OK");
    end else begin
      $display("[line_clip_outcode] ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #20ms;
    $display("[line_clip_outcode] ERROR");
    $finish;
  end

endmodule
